// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define MPD_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication checked at every clock edge outside reset.
`define MPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/mpd_pkg.sv =====
// Types and constants of the meter packet deframer.
package mpd_pkg;

  localparam int IDX_W       = 5;
  localparam int FIELD_DEPTH = 20;
  localparam int FIELD_AW    = 5;

  localparam logic [7:0]       HEAD_BYTE    = 8'h55;
  localparam logic [IDX_W-1:0] PKT_LEN_IDX  = 5'd22;
  localparam logic [IDX_W-1:0] SUM_LAST_IDX = 5'd21;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_TIMEOUT = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    RES_OK         = 2'd0,
    RES_BAD_HEADER = 2'd1,
    RES_BAD_SUM    = 2'd2,
    RES_TIMEOUT    = 2'd3
  } result_code_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    result_code_t       result_code;
    logic [23:0]        current_rms;
    logic [23:0]        voltage_rms;
    logic [23:0]        fast_current_rms;
    logic signed [23:0] active_power;
    logic [23:0]        pulse_count;
    logic [15:0]        line_period;
    logic [7:0]         chip_status;
  } res_item_t;

  typedef struct packed {
    logic      res_valid;
    res_item_t res;
  } trk_out_t;

endpackage

// ===== rtl/mpd_ifs.sv =====
// Valid/ready channel interfaces for received bytes and packet results.
interface mpd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, kind, rx_byte, frame_start, input ready);
  modport sink (input valid, kind, rx_byte, frame_start, output ready);
endinterface

interface mpd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_code;
  logic [23:0]        current_rms;
  logic [23:0]        voltage_rms;
  logic [23:0]        fast_current_rms;
  logic signed [23:0] active_power;
  logic [23:0]        pulse_count;
  logic [15:0]        line_period;
  logic [7:0]         chip_status;

  modport source (output valid, result_code, current_rms, voltage_rms, fast_current_rms,
                  active_power, pulse_count, line_period, chip_status, input ready);
  modport sink (input valid, result_code, current_rms, voltage_rms, fast_current_rms,
                active_power, pulse_count, line_period, chip_status, output ready);
endinterface

// ===== rtl/mpd_in_stage.sv =====
// Input register of the deframer.
`include "assert_macros.svh"

module mpd_in_stage (
  input  logic              clk,
  input  logic              rst,
  mpd_in_if.sink            bytes,
  input  logic              advance,
  output logic              valid,
  output mpd_pkg::in_item_t item
);
  import mpd_pkg::*;

  logic load;

  assign bytes.ready = !valid || advance;
  assign load        = bytes.valid && bytes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.kind        <= kind_t'(bytes.kind);
      item.rx_byte     <= bytes.rx_byte;
      item.frame_start <= bytes.frame_start;
    end
  end

  // a held item is never overwritten before it moves on
  `MPD_ASSERT(a_no_overwrite, !(load && valid && !advance), "input stage overwritten")
  `MPD_ASSERT_IMP(a_adv_valid, advance, valid, "advance without item")

endmodule

// ===== rtl/mpd_frame_tracker.sv =====
// Frame state: byte index, running sum, header flag and payload bytes.
`include "assert_macros.svh"

module mpd_frame_tracker (
  input  logic              clk,
  input  logic              rst,
  input  mpd_pkg::in_item_t item,
  input  logic              advance,
  output mpd_pkg::trk_out_t trk
);
  import mpd_pkg::*;

  logic [IDX_W-1:0]    byte_index, byte_index_next;
  logic [7:0]          running_sum, running_sum_next;
  logic                header_good, header_good_next;
  logic                frame_active, frame_active_next;
  logic [7:0]          field_bytes [FIELD_DEPTH];

  logic                eff_active;
  logic [IDX_W-1:0]    eff_idx;
  logic [7:0]          eff_sum;
  logic                field_we;
  logic [FIELD_AW-1:0] field_addr;

  always_comb begin
    eff_active = item.frame_start || frame_active;
    eff_idx    = item.frame_start ? '0 : byte_index;
    eff_sum    = item.frame_start ? 8'd0 : running_sum;
    field_addr = FIELD_AW'(eff_idx - 5'd1);

    byte_index_next   = byte_index;
    running_sum_next  = running_sum;
    header_good_next  = header_good;
    frame_active_next = frame_active;
    field_we          = 1'b0;
    trk               = '0;

    if (item.kind == KIND_TIMEOUT) begin
      frame_active_next   = 1'b0;
      byte_index_next     = '0;
      running_sum_next    = 8'd0;
      trk.res_valid       = 1'b1;
      trk.res.result_code = RES_TIMEOUT;
    end else if (eff_active) begin
      if (eff_idx >= PKT_LEN_IDX) begin
        // runaway index: drop the frame quietly
        frame_active_next = 1'b0;
        byte_index_next   = '0;
        running_sum_next  = eff_sum;
      end else if (eff_idx < SUM_LAST_IDX) begin
        frame_active_next = 1'b1;
        running_sum_next  = eff_sum + item.rx_byte;
        byte_index_next   = eff_idx + 5'd1;
        if (eff_idx == '0) begin
          header_good_next = (item.rx_byte == HEAD_BYTE);
        end else begin
          field_we = 1'b1;
        end
      end else begin
        // checksum byte closes the frame
        frame_active_next = 1'b0;
        byte_index_next   = '0;
        running_sum_next  = 8'd0;
        trk.res_valid     = 1'b1;
        if (!header_good) begin
          trk.res.result_code = RES_BAD_HEADER;
        end else if (~eff_sum != item.rx_byte) begin
          trk.res.result_code = RES_BAD_SUM;
        end else begin
          trk.res.result_code      = RES_OK;
          trk.res.current_rms      = {field_bytes[2], field_bytes[1], field_bytes[0]};
          trk.res.voltage_rms      = {field_bytes[5], field_bytes[4], field_bytes[3]};
          trk.res.fast_current_rms = {field_bytes[8], field_bytes[7], field_bytes[6]};
          trk.res.active_power     = $signed({field_bytes[11], field_bytes[10],
                                              field_bytes[9]});
          trk.res.pulse_count      = {field_bytes[14], field_bytes[13], field_bytes[12]};
          trk.res.line_period      = {field_bytes[16], field_bytes[15]};
          trk.res.chip_status      = field_bytes[18];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      running_sum  <= 8'd0;
      header_good  <= 1'b0;
      frame_active <= 1'b0;
    end else if (advance) begin
      byte_index   <= byte_index_next;
      running_sum  <= running_sum_next;
      header_good  <= header_good_next;
      frame_active <= frame_active_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FIELD_DEPTH; i++) begin
      if (advance && field_we && field_addr == FIELD_AW'(i)) begin
        field_bytes[i] <= item.rx_byte;
      end
    end
  end

  `MPD_ASSERT(a_idx_range, byte_index <= SUM_LAST_IDX, "byte index past checksum byte")
  `MPD_ASSERT_IMP(a_idle_idx, !frame_active, byte_index == '0, "index nonzero outside frame")

endmodule

// ===== rtl/mpd_out_stage.sv =====
// Result register driving the output channel.
`include "assert_macros.svh"

module mpd_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  mpd_pkg::res_item_t res,
  output logic               slot_free,
  mpd_out_if.source          results
);
  import mpd_pkg::*;

  logic      valid;
  res_item_t data;

  assign slot_free = !valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (results.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign results.valid            = valid;
  assign results.result_code      = data.result_code;
  assign results.current_rms      = data.current_rms;
  assign results.voltage_rms      = data.voltage_rms;
  assign results.fast_current_rms = data.fast_current_rms;
  assign results.active_power     = data.active_power;
  assign results.pulse_count      = data.pulse_count;
  assign results.line_period      = data.line_period;
  assign results.chip_status      = data.chip_status;

  // a waiting result is never replaced
  `MPD_ASSERT(a_no_clobber, !(load && valid && !results.ready), "result overwritten")

endmodule

// ===== rtl/meter_packet_deframer_unit.sv =====
// Top level of the meter packet deframer.
//
//   channel   dir  payload                                    item
//   bytes     in   kind, rx_byte, frame_start                 one received byte or timeout
//   results   out  result_code, three RMS values, power,      one finished packet or timeout
//                  pulse_count, line_period, chip_status
//
// One item per cycle unless a result meets a full result register. An accepted
// item waits in the input register; its result, if any, is registered as it leaves.
// rst (synchronous) clears both stage valids and the frame state; payload
// bytes are not cleared, every frame writes them before its checksum byte.
// A stall on results holds the result register; the input register holds
// only an item that makes a result while that register is still full.
module meter_packet_deframer_unit (
  input  logic      clk,
  input  logic      rst,
  mpd_in_if.sink    bytes,
  mpd_out_if.source results
);
  import mpd_pkg::*;

  logic      stage_valid;
  in_item_t  stage_item;
  trk_out_t  trk;
  logic      slot_free;
  logic      advance;

  // byte items with no result move on even when the result side stalls
  assign advance = stage_valid && (!trk.res_valid || slot_free);

  mpd_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes),
    .advance (advance),
    .valid   (stage_valid),
    .item    (stage_item)
  );

  mpd_frame_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .item    (stage_item),
    .advance (advance),
    .trk     (trk)
  );

  mpd_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && trk.res_valid),
    .res       (trk.res),
    .slot_free (slot_free),
    .results   (results)
  );

endmodule
